// ===== hw/rtl/rkav_pkg.sv =====
`timescale 1ns / 1ps
package rkav_pkg;

  localparam int unsigned CordicSteps = 28;
  localparam int unsigned DivSteps    = 16;

  // configuration register indexes
  localparam logic [1:0] RegDirMode  = 2'd0;
  localparam logic [1:0] RegDzWidth  = 2'd1;
  localparam logic [1:0] RegDzCentre = 2'd2;

  // Sideband that rides along the CORDIC chain
  typedef struct packed {
    logic        dx_neg;
    logic        dy_neg;
    logic        special;    // coincident points or pointer on an axis
    logic [31:0] t_special;  // exact angle for the special case, Q0.32 turns
  } cq_side_t;

  typedef struct packed {
    logic        vld;
    logic [63:0] x;
    logic [63:0] y;
    logic [31:0] z;
    cq_side_t    side;
  } cordic_t;

  typedef struct packed {
    logic        vld;
    logic [39:0] rem;
    logic [18:0] den;
    logic [15:0] quo;
    logic        fixed;      // value already known, divider result ignored
    logic [16:0] fixed_val;
    logic [15:0] angle;
  } div_t;

  // atan(2^-i) / (2*pi) in Q0.32 turns
  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/rkav_cordic_cell.sv =====
`timescale 1ns / 1ps
module rkav_cordic_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [4:0]            step_i,
  input  rkav_pkg::cordic_t     cell_i,
  output rkav_pkg::cordic_t     cell_o
);

  logic              vld_q;
  logic [63:0]       x_q, x_d, y_q, y_d;
  logic [31:0]       z_q, z_d;
  rkav_pkg::cq_side_t side_q;
  logic [63:0]       xs, ys;

  // vectoring step: drive y toward zero
  always_comb begin
    ys = 64'($signed(cell_i.y) >>> step_i);
    xs = cell_i.x >> step_i;
    if (!cell_i.y[63]) begin
      x_d = cell_i.x + ys;
      y_d = cell_i.y - xs;
      z_d = cell_i.z + rkav_pkg::atan_turns(step_i);
    end else begin
      x_d = cell_i.x - ys;
      y_d = cell_i.y + xs;
      z_d = cell_i.z - rkav_pkg::atan_turns(step_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= cell_i.side;
    end
  end

  assign cell_o = '{vld: vld_q, x: x_q, y: y_q, z: z_q, side: side_q};

endmodule

// ===== hw/rtl/rkav_div_cell.sv =====
`timescale 1ns / 1ps
module rkav_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [3:0]        bit_i,
  input  rkav_pkg::div_t    cell_i,
  output rkav_pkg::div_t    cell_o
);

  logic            vld_q;
  rkav_pkg::div_t  data_q, data_d;
  logic [39:0]     trial;

  // one restoring step: quotient bit bit_i
  always_comb begin
    trial  = 40'(cell_i.den) << bit_i;
    data_d = cell_i;
    if (cell_i.rem >= trial) begin
      data_d.rem = cell_i.rem - trial;
      data_d.quo = cell_i.quo | (16'd1 << bit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    cell_o     = data_q;
    cell_o.vld = vld_q;
  end

endmodule

// ===== hw/rtl/rotary_knob_angle_to_value_core.sv =====
`timescale 1ns / 1ps
// Rotary knob core: takes a knob centre and a pointer position (screen
// coordinates, y down) and returns the pointer angle in turns (Q0.16,
// counterclockwise) and a knob value in Q1.16 with 65536 = 1.0. A dead zone
// of dead_zone_width around dead_zone_centre snaps to 0 or 1 depending on
// side and direction_mode; the live arc maps linearly. One transaction is
// accepted per cycle unless stalled; the pipeline is the 28-cell CORDIC chain
// and the 16-cell restoring divider chain plus front end, mapping and output
// stages, and stalls as one while the output holds a result not yet taken.
// Configuration is to be written only while idle; the block does not enforce it.
module rotary_knob_angle_to_value_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // centre_x, centre_y, point_x, point_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // knob_value[16:0], pointer_angle[32:17], zero pad
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [16:0] ValOne    = 17'h10000;

  // ---------------- configuration registers
  logic        dir_q;
  logic [15:0] dzw_q, dzc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      dzw_q <= '0;
      dzc_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rkav_pkg::RegDirMode:  dir_q <= cfg_data_i[0];
        rkav_pkg::RegDzWidth:  dzw_q <= cfg_data_i;
        rkav_pkg::RegDzCentre: dzc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline advance: everything moves when output is free
  logic adv;
  logic out_vld_q;
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------- stage 1: differences
  logic               s1_vld_q;
  logic signed [16:0] dx_q, dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (adv) s1_vld_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q <= 17'($signed(s_axis_tdata[47:32])) - 17'($signed(s_axis_tdata[15:0]));
      dy_q <= 17'($signed(s_axis_tdata[31:16])) - 17'($signed(s_axis_tdata[63:48]));
    end
  end

  // ---------------- stage 2: magnitudes, special cases, normalize amount
  logic              s2_vld_q;
  logic [16:0]       ca_q, co_q;
  logic [5:0]        sh_q;
  rkav_pkg::cq_side_t side_q;

  logic [16:0]        adx, ady, big;
  logic [4:0]         msb;
  rkav_pkg::cq_side_t side_d;

  always_comb begin
    adx = dx_q[16] ? 17'(-dx_q) : 17'(dx_q);
    ady = dy_q[16] ? 17'(-dy_q) : 17'(dy_q);
    big = (adx > ady) ? adx : ady;
    msb = '0;
    for (int i = 0; i < 17; i++) begin
      if (big[i]) msb = 5'(i);
    end
    side_d.dx_neg    = dx_q[16];
    side_d.dy_neg    = dy_q[16];
    side_d.special   = (dx_q == 0) || (dy_q == 0);
    // exact angles: 0 for coincident or +x, quarter turns on the y axis, half a turn on -x
    if (dx_q == 0 && dy_q != 0)
      side_d.t_special = dy_q[16] ? 32'hC000_0000 : 32'h4000_0000;
    else if (dy_q == 0 && dx_q[16])
      side_d.t_special = 32'h8000_0000;
    else
      side_d.t_special = 32'h0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (adv) s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ca_q   <= adx;
      co_q   <= ady;
      sh_q   <= 6'd60 - 6'(msb);
      side_q <= side_d;
    end
  end

  // ---------------- stage 3: normalized CORDIC input
  rkav_pkg::cordic_t cq [rkav_pkg::CordicSteps+1];
  logic              c0_vld_q;
  logic [63:0]       c0_x_q, c0_y_q;
  rkav_pkg::cq_side_t c0_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c0_vld_q <= 1'b0;
    else if (adv) c0_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c0_x_q    <= 64'(ca_q) << sh_q;
      c0_y_q    <= 64'(co_q) << sh_q;
      c0_side_q <= side_q;
    end
  end

  assign cq[0] = '{vld: c0_vld_q, x: c0_x_q, y: c0_y_q, z: 32'd0, side: c0_side_q};

  for (genvar g = 0; g < rkav_pkg::CordicSteps; g++) begin : g_cordic
    rkav_cordic_cell u_cell (
      .clk_i,
      .rst_ni,
      .en_i   (adv),
      .step_i (5'(g)),
      .cell_i (cq[g]),
      .cell_o (cq[g+1])
    );
  end

  // ---------------- quadrant fold and rounding to Q0.16
  rkav_pkg::cordic_t ce;
  logic              qa_vld_q;
  logic [15:0]       ang_q;
  logic [31:0]       phi, t_full, t_rnd;

  assign ce = cq[rkav_pkg::CordicSteps];

  always_comb begin
    phi = ce.z;
    if (ce.side.special)
      t_full = ce.side.t_special;
    else if (!ce.side.dx_neg)
      t_full = ce.side.dy_neg ? (32'd0 - phi) : phi;
    else
      t_full = ce.side.dy_neg ? (32'h8000_0000 + phi) : (32'h8000_0000 - phi);
    t_rnd = t_full + 32'h0000_8000;   // round half up, 1.0 wraps to 0
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) qa_vld_q <= 1'b0;
    else if (adv) qa_vld_q <= ce.vld;
  end

  always_ff @(posedge clk_i) begin
    if (adv) ang_q <= t_rnd[31:16];
  end

  // ---------------- dead-zone mapping, in half-LSB units
  logic               mp_vld_q, mp_fixed_q;
  logic [16:0]        mp_val_q;
  logic [19:0]        mp_num_q;
  logic [17:0]        mp_dist_q;
  logic [15:0]        mp_ang_q;

  logic signed [21:0] one2, a2, c2, dw, l2, r2, dist2, num;
  logic               mp_fixed;
  logic [16:0]        mp_val;

  always_comb begin
    one2  = 22'sd131072;
    a2    = $signed({5'd0, ang_q, 1'b0});
    c2    = $signed({5'd0, dzc_q, 1'b0});
    dw    = $signed({6'd0, dzw_q});
    l2    = c2 - dw;
    if (l2 < 0) l2 = l2 + one2;
    r2    = c2 + dw;
    if (r2 > one2) r2 = r2 - one2;
    dist2 = one2 - (dw <<< 1);
    num      = '0;
    mp_fixed = 1'b1;
    mp_val   = '0;
    if (a2 == l2) begin
      mp_val = ValOne;                       // left edge wins
    end else if (a2 == r2) begin
      mp_val = '0;
    end else if (l2 > r2) begin
      if (a2 < r2)      mp_val = dir_q ? ValOne : 17'd0;
      else if (a2 > l2) mp_val = dir_q ? 17'd0 : ValOne;
      else begin
        mp_fixed = 1'b0;
        num = dir_q ? ((l2 - a2) <<< 1) : ((a2 - r2) <<< 1);
      end
    end else if (a2 < r2 && a2 > l2) begin
      // dead zone not wrapping: side is chosen against the centre
      if (a2 > c2) mp_val = dir_q ? ValOne : 17'd0;
      else         mp_val = dir_q ? 17'd0 : ValOne;
    end else if (a2 < r2) begin
      mp_fixed = 1'b0;
      num = dir_q ? ((l2 - a2) <<< 1) : ((one2 - r2 + a2) <<< 1);
    end else begin
      mp_fixed = 1'b0;
      num = dir_q ? ((l2 + one2 - a2) <<< 1) : ((a2 - r2) <<< 1);
    end
    if (num < 0) num = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mp_vld_q <= 1'b0;
    else if (adv) mp_vld_q <= qa_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mp_fixed_q <= mp_fixed;
      mp_val_q   <= mp_val;
      mp_num_q   <= num[19:0];
      mp_dist_q  <= dist2[17:0];
      mp_ang_q   <= ang_q;
    end
  end

  // ---------------- divider setup and saturation check
  rkav_pkg::div_t dq [rkav_pkg::DivSteps+1];
  logic           d0_vld_q;
  rkav_pkg::div_t d0_q, d0_d;
  logic [39:0]    n_full;
  logic [18:0]    den;
  logic           sat;

  always_comb begin
    n_full = (40'(mp_num_q) << 16) + 40'(mp_dist_q);
    den    = {mp_dist_q, 1'b0};
    sat    = n_full >= (40'(den) << 16);   // quotient would reach 1.0
    d0_d.vld       = 1'b0;
    d0_d.rem       = n_full;
    d0_d.den       = den;
    d0_d.quo       = '0;
    d0_d.fixed     = mp_fixed_q || sat;
    d0_d.fixed_val = mp_fixed_q ? mp_val_q : ValOne;
    d0_d.angle     = mp_ang_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d0_vld_q <= 1'b0;
    else if (adv) d0_vld_q <= mp_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) d0_q <= d0_d;
  end

  always_comb begin
    dq[0]     = d0_q;
    dq[0].vld = d0_vld_q;
  end

  for (genvar g = 0; g < rkav_pkg::DivSteps; g++) begin : g_div
    rkav_div_cell u_cell (
      .clk_i,
      .rst_ni,
      .en_i   (adv),
      .bit_i  (4'(rkav_pkg::DivSteps - 1 - g)),
      .cell_i (dq[g]),
      .cell_o (dq[g+1])
    );
  end

  // ---------------- output register
  rkav_pkg::div_t de;
  logic [16:0]    knob_q;
  logic [15:0]    out_ang_q;

  assign de = dq[rkav_pkg::DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= de.vld;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      knob_q    <= de.fixed ? de.fixed_val : {1'b0, de.quo};
      out_ang_q <= de.angle;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_ang_q, knob_q};

  // ---------------- assertions
  a_knob_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'd0)
    else $error("knob value above 1.0");

  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    de.vld && !de.fixed |-> de.rem < 40'(de.den))
    else $error("divider remainder not reduced");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(knob_q) && $stable(out_ang_q))
    else $error("output changed while stalled");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Knob testbench: drives coordinate transactions into the core, predicts the
// pointer angle (28-step CORDIC atan2 in Q0.32 turns) and the dead-zone
// knob mapping, and checks each output transaction in order.
module testbench;

  localparam int unsigned Latency = 51;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [16:0] knob;
    logic [15:0] angle;
  } knob_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  rotary_knob_angle_to_value_core dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow copies of the configuration registers
  logic dir_mode = 1'b0;
  logic [15:0] dz_width = '0;
  logic [15:0] dz_centre = '0;

  knob_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_count = 0;
  logic done = 1'b0;

  // CORDIC atan in the first quadrant, Q0.32 turns
  function automatic logic [31:0] first_quadrant_turns(logic [63:0] ca, logic [63:0] co);
    logic [63:0] big, x, y, xs, ys;
    logic [31:0] z;
    int msb, sh;
    big = (ca > co) ? ca : co;
    msb = 0;
    while (msb < 63 && (big >> (msb + 1)) != 0) msb++;
    sh = (msb < 60) ? 60 - msb : 0;
    x = ca << sh;
    y = co << sh;
    z = '0;
    for (int i = 0; i < rkav_pkg::CordicSteps; i++) begin
      ys = $signed(y) >>> i;
      xs = x >> i;
      if (!y[63]) begin
        x = x + ys; y = y - xs; z = z + rkav_pkg::atan_turns(5'(i));
      end else begin
        x = x - ys; y = y + xs; z = z - rkav_pkg::atan_turns(5'(i));
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] pointer_angle(logic [63:0] d);
    longint dx, dy;
    logic [31:0] t, phi;
    logic [32:0] r;
    dx = longint'($signed(d[47:32])) - longint'($signed(d[15:0]));
    dy = longint'($signed(d[31:16])) - longint'($signed(d[63:48]));
    if (dx == 0 && dy == 0) t = 32'h0;
    else if (dx == 0) t = (dy > 0) ? 32'h4000_0000 : 32'hC000_0000;
    else if (dy == 0) t = (dx > 0) ? 32'h0 : 32'h8000_0000;
    else begin
      phi = first_quadrant_turns(64'(dx < 0 ? -dx : dx), 64'(dy < 0 ? -dy : dy));
      if (dx > 0) t = (dy > 0) ? phi : -phi;
      else t = (dy > 0) ? 32'h8000_0000 - phi : 32'h8000_0000 + phi;
    end
    r = {1'b0, t} + 33'h8000;
    return r[31:16];
  endfunction

  function automatic logic [16:0] arc_ratio(longint num, longint span);
    longint q;
    if (num < 0) num = 0;
    q = (num * 65536 + span / 2) / span;
    return (q > 65536) ? 17'd65536 : 17'(q);
  endfunction

  function automatic knob_result_t predict_knob(logic [63:0] d);
    knob_result_t res;
    longint a2, c2, w, l2, r2, dist2, one;
    logic s;
    one = 65536;
    res.angle = pointer_angle(d);
    a2 = 2 * longint'(res.angle);
    c2 = 2 * longint'(dz_centre);
    w = longint'(dz_width);
    l2 = c2 - w; r2 = c2 + w; dist2 = 2 * one - 2 * w;
    s = dir_mode;
    if (l2 < 0) l2 += 2 * one;
    if (r2 > 2 * one) r2 -= 2 * one;
    if (a2 == l2) res.knob = 17'd65536;
    else if (a2 == r2) res.knob = '0;
    else if (l2 > r2) begin
      if (a2 < r2) res.knob = s ? 17'd65536 : 17'd0;
      else if (a2 > l2) res.knob = s ? 17'd0 : 17'd65536;
      else res.knob = arc_ratio(s ? 2 * (l2 - a2) : 2 * (a2 - r2), 2 * dist2);
    end else if (a2 < r2 && a2 > l2) begin
      if (a2 > c2) res.knob = s ? 17'd65536 : 17'd0;
      else res.knob = s ? 17'd0 : 17'd65536;
    end else if (a2 < r2) begin
      res.knob = arc_ratio(s ? 2 * (l2 - a2) : 2 * (2 * one - r2 + a2), 2 * dist2);
    end else begin
      res.knob = arc_ratio(s ? 2 * (l2 + 2 * one - a2) : 2 * (a2 - r2), 2 * dist2);
    end
    return res;
  endfunction

  // output side: random stall, compare each transaction against the queue head
  always @(posedge clk_i) begin
    knob_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[16:0] !== want.knob) begin
            $error("knob_value: expected %0d, got %0d", want.knob, m_axis_tdata[16:0]);
            errors++;
          end
          if (m_axis_tdata[32:17] !== want.angle) begin
            $error("pointer_angle: expected %0d, got %0d", want.angle,
                   m_axis_tdata[32:17]);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: cycles in a row with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni && !done) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_count <= 0;
      else if (idle_count >= WatchLimit) begin
        $display("*** FAILED ***");
        $finish;
      end else idle_count <= idle_count + 1;
    end
  end

  // valid stays high after a transaction until the next item or an idle cycle
  task automatic send_coords(logic signed [15:0] cx, logic signed [15:0] cy,
                             logic signed [15:0] px, logic signed [15:0] py);
    logic [63:0] d;
    d = {py, px, cy, cx};
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= d;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_knob(d));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      rkav_pkg::RegDirMode: dir_mode = val[0];
      rkav_pkg::RegDzWidth: dz_width = val;
      rkav_pkg::RegDzCentre: dz_centre = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic m, logic [15:0] w, logic [15:0] c);
    drain();
    write_reg(rkav_pkg::RegDirMode, {15'd0, m});
    write_reg(rkav_pkg::RegDzWidth, w);
    write_reg(rkav_pkg::RegDzCentre, c);
    cfg_we_i <= 1'b0;
  endtask

  // extremes, axes, coincident points, quadrant diagonals
  task automatic test_directed();
    send_coords(0, 0, 0, 0);
    send_coords(100, 100, 100, 100);
    send_coords(0, 0, 10, 0);
    send_coords(0, 0, 0, -10);
    send_coords(0, 0, -10, 0);
    send_coords(0, 0, 0, 10);
    send_coords(0, 0, 5, -5);
    send_coords(0, 0, -5, -5);
    send_coords(0, 0, -5, 5);
    send_coords(0, 0, 5, 5);
    send_coords(-32768, -32768, 32767, 32767);
    send_coords(32767, 32767, -32768, -32768);
    send_coords(-32768, 32767, 32767, -32768);
    send_coords(32767, -32768, -32768, 32767);
    send_coords(0, 0, 32767, -1);
    send_coords(0, 0, 32767, 1);
    send_coords(0, 0, 1, -32768);
  endtask

  // pointer landing exactly on dead-zone edges (quarter-turn centre, then a centre near one turn)
  task automatic test_edges();
    configure(1'b0, 16'h4000, 16'h4000);   // edges at 1/8 and 3/8 turn
    send_coords(0, 0, 100, -100);
    send_coords(0, 0, -100, -100);
    send_coords(0, 0, 0, -100);
    configure(1'b1, 16'h0000, 16'h4000);   // zero width, edges meet at centre
    send_coords(0, 0, 0, -100);
    send_coords(0, 0, 100, -100);
    configure(1'b0, 16'h2000, 16'hF000);   // right edge lands exactly on one turn, left unwrapped
    send_coords(0, 0, 100, 0);
    send_coords(0, 0, 100, 1);
  endtask

  task automatic test_random(int n);
    int r;
    logic signed [15:0] cx, cy;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(3);
      if (r == 0)
        send_coords(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else begin
        cx = 16'(int'($urandom_range(2000)) - 1000);
        cy = 16'(int'($urandom_range(2000)) - 1000);
        if (r == 1)
          send_coords(cx, cy, cx + $signed(16'($urandom_range(200) - 100)),
                      cy + $signed(16'($urandom_range(200) - 100)));
        else
          send_coords(cx, cy, cx + $signed(16'($urandom_range(4) - 2)) * 16'sd64,
                      cy + $signed(16'($urandom_range(4) - 2)) * 16'sd64);
      end
    end
  endtask

  // several register settings, the first five each run under every idling pattern, then two random ones
  task automatic test_settings();
    logic [15:0] widths[5] = '{16'h0000, 16'hFFFF, 16'h2000, 16'h8000, 16'h0001};
    logic [15:0] centres[5] = '{16'h0000, 16'hFFFF, 16'hC000, 16'h4000, 16'h8123};
    int send_pcts[4] = '{0, 50, 0, 29};
    int recv_pcts[4] = '{0, 0, 50, 29};
    for (int k = 0; k < 5; k++) begin
      configure(k[0], widths[k], centres[k]);
      for (int p = 0; p < 4; p++) begin
        send_idle_pct = send_pcts[p];
        recv_stall_pct = recv_pcts[p];
        test_random(50);
      end
    end
    for (int k = 0; k < 2; k++) begin
      configure(1'($urandom), 16'($urandom), 16'($urandom));
      test_random(100);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_edges();
    test_settings();
    drain();
    done = 1'b1;
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
